@@ sv/ppms_pkg.sv @@
package ppms_pkg;

  // Position and fixed-point geometry
  localparam int POS_W    = 24;
  localparam int ERR_W    = POS_W + 1;
  localparam int GAIN_W   = 24;
  localparam int FRAC_W   = 16;
  localparam int TOL_W    = 16;
  localparam int REL_TOL_Q16 = 655;

  // Drive saturation
  localparam int DRIVE_MAX = 255;
  localparam int DRV_W     = $clog2(DRIVE_MAX + 1) + 1;
  localparam int INT_W     = DRV_W + FRAC_W;

  // Counter widths
  localparam int PER_W   = 16;
  localparam int RUN_W   = 24;
  localparam int STILL_W = 8;

  // Configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [2:0] {
    FN_TICK  = 3'd0,
    FN_GOTO  = 3'd1,
    FN_OPEN  = 3'd2,
    FN_CLOSE = 3'd3,
    FN_STOP  = 3'd4
  } ppms_func_t;

  typedef enum logic [1:0] {
    FIN_NONE    = 2'd0,
    FIN_SETTLED = 2'd1,
    FIN_TIMEOUT = 2'd2,
    FIN_STOPPED = 2'd3
  } ppms_fin_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P        = 4'd0,
    REG_GAIN_I        = 4'd1,
    REG_GAIN_D        = 4'd2,
    REG_SAMPLE_PERIOD = 4'd3,
    REG_SETTLE_WINDOW = 4'd4,
    REG_SETTLE_COUNT  = 4'd5,
    REG_MAX_RUN       = 4'd6,
    REG_ABS_TOL       = 4'd7
  } ppms_reg_t;

  // Loop gains handed to the PID datapath
  typedef struct packed {
    logic [GAIN_W-1:0] gain_p;
    logic [GAIN_W-1:0] gain_i;
    logic [GAIN_W-1:0] gain_d;
  } ppms_gains_t;

endpackage

@@ sv/ppms_close.sv @@
// Closeness test: |a-b| <= tol, or |a-b|*2^16 <= REL_TOL_Q16 * max(|b|,1)
module ppms_close import ppms_pkg::*; (
  input  logic signed [POS_W-1:0] a_i,
  input  logic signed [POS_W-1:0] b_i,
  input  logic        [TOL_W-1:0] abs_tol_i,
  output logic                    close_o
);

  localparam int CMP_W = ERR_W + FRAC_W;

  logic signed [ERR_W-1:0] diff;
  logic        [ERR_W-1:0] err;
  logic signed [ERR_W-1:0] b_ext;
  logic        [ERR_W-1:0] b_mag;
  logic        [ERR_W-1:0] den;
  logic        [CMP_W-1:0] lhs;
  logic        [CMP_W-1:0] rhs;

  always_comb begin
    diff  = ERR_W'(a_i) - ERR_W'(b_i);
    err   = diff[ERR_W-1] ? ERR_W'(-diff) : ERR_W'(diff);
    b_ext = ERR_W'(b_i);
    b_mag = b_ext[ERR_W-1] ? ERR_W'(-b_ext) : ERR_W'(b_ext);
    den   = (b_mag == '0) ? ERR_W'(1) : b_mag;
    lhs   = {err, FRAC_W'(0)};
    rhs   = CMP_W'(FRAC_W'(REL_TOL_Q16)) * CMP_W'(den);
  end

  assign close_o = (err <= ERR_W'(abs_tol_i)) || (lhs <= rhs);

endmodule

@@ sv/ppms_pid.sv @@
// One controller update: clamped integral, output with derivative on measurement
module ppms_pid import ppms_pkg::*; (
  input  ppms_gains_t              gains_i,
  input  logic signed [POS_W-1:0]  setpoint_i,
  input  logic signed [POS_W-1:0]  pos_i,
  input  logic signed [POS_W-1:0]  prev_pos_i,
  input  logic signed [INT_W-1:0]  integ_i,
  output logic signed [INT_W-1:0]  integ_o,
  output logic signed [DRV_W-1:0]  drive_o
);

  localparam int PROD_W = GAIN_W + 1 + ERR_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int LIM    = DRIVE_MAX << FRAC_W;
  localparam logic signed [SUM_W-1:0] LIM_P = SUM_W'(LIM);
  localparam logic signed [SUM_W-1:0] LIM_N = -LIM_P;
  localparam logic signed [INT_W:0]   RND   = (INT_W+1)'((1 << FRAC_W) - 1);

  logic signed [ERR_W-1:0]  err;
  logic signed [ERR_W-1:0]  dpos;
  logic signed [PROD_W-1:0] prod_p;
  logic signed [PROD_W-1:0] prod_i;
  logic signed [PROD_W-1:0] prod_d;
  logic signed [SUM_W-1:0]  sum_i;
  logic signed [SUM_W-1:0]  sum_o;
  logic signed [INT_W-1:0]  out_c;
  logic signed [INT_W:0]    out_t;

  function automatic logic signed [INT_W-1:0] clamp(input logic signed [SUM_W-1:0] x);
    logic signed [SUM_W-1:0] y;
    if (x > LIM_P) y = LIM_P;
    else if (x < LIM_N) y = LIM_N;
    else y = x;
    return y[INT_W-1:0];
  endfunction

  // Error terms and the three products
  always_comb begin
    err    = ERR_W'(setpoint_i) - ERR_W'(pos_i);
    dpos   = ERR_W'(pos_i) - ERR_W'(prev_pos_i);
    prod_p = PROD_W'($signed({1'b0, gains_i.gain_p})) * PROD_W'(err);
    prod_i = PROD_W'($signed({1'b0, gains_i.gain_i})) * PROD_W'(err);
    prod_d = PROD_W'($signed({1'b0, gains_i.gain_d})) * PROD_W'(dpos);
  end

  // Integral update and output sum, both clamped
  always_comb begin
    sum_i   = SUM_W'(prod_i) + SUM_W'(integ_i);
    integ_o = clamp(sum_i);
    sum_o   = SUM_W'(prod_p) + SUM_W'(integ_o) - SUM_W'(prod_d);
    out_c   = clamp(sum_o);
    // truncate toward zero
    out_t   = out_c[INT_W-1] ? ((INT_W+1)'(out_c) + RND) : (INT_W+1)'(out_c);
    drive_o = DRV_W'(out_t >>> FRAC_W);
  end

endmodule

@@ sv/position_pid_move_supervisor.sv @@
// A request accepted into the input register has its result written into the
// result register once the result slot is free (out_valid low or out_ready high).
// Throughput: one request per cycle unless out_ready stalls the result; the input
// register feeds a combinational datapath (three parallel 25x25 multiplies).
// Reset (rst_n low, synchronous): all move state and counters clear, drive 0,
// configuration returns to its defaults, both channels empty.
module position_pid_move_supervisor import ppms_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  // requests
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [2:0]                in_func,
  input  logic signed [POS_W-1:0]   in_position,
  input  logic signed [POS_W-1:0]   in_target,
  // results
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [DRV_W-1:0]   out_drive,
  output logic                      out_moving,
  output logic [1:0]                out_finish,
  // configuration writes
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data
);

  // Configuration registers
  ppms_gains_t        gains_r;
  logic [PER_W-1:0]   sample_period_r;
  logic [PER_W-1:0]   settle_window_r;
  logic [STILL_W-1:0] settle_count_r;
  logic [RUN_W-1:0]   max_run_r;
  logic [TOL_W-1:0]   abs_tol_r;

  // Input register
  logic                    in_valid_r;
  logic [2:0]              func_r;
  logic signed [POS_W-1:0] pos_r;
  logic signed [POS_W-1:0] tgt_r;

  // Move state
  logic signed [POS_W-1:0] setpoint_r, setpoint_nxt;
  logic signed [INT_W-1:0] integ_r, integ_nxt;
  logic signed [POS_W-1:0] prev_pos_r, prev_pos_nxt;
  logic                    loop_active_r, loop_active_nxt;
  logic                    move_active_r, move_active_nxt;
  logic [PER_W-1:0]        since_sample_r, since_sample_nxt;
  logic [PER_W-1:0]        since_check_r, since_check_nxt;
  logic [RUN_W-1:0]        since_start_r, since_start_nxt;
  logic [STILL_W-1:0]      still_r, still_nxt;
  logic signed [POS_W-1:0] ref_pos_r, ref_pos_nxt;
  logic signed [DRV_W-1:0] drive_r, drive_nxt;

  // Result register
  logic                    out_valid_r;
  logic signed [DRV_W-1:0] out_drive_r;
  logic                    out_moving_r;
  ppms_fin_t               out_finish_r;
  ppms_fin_t               fin_nxt;

  logic                    advance;
  logic                    tgt_near;
  logic                    settle_close;
  logic signed [INT_W-1:0] pid_integ;
  logic signed [DRV_W-1:0] pid_drive;

  localparam logic signed [DRV_W-1:0] DRIVE_POS = DRV_W'(DRIVE_MAX);
  localparam logic signed [DRV_W-1:0] DRIVE_NEG = -DRIVE_POS;

  // Handshake: the input register moves on whenever the result slot frees
  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || !out_valid_r || out_ready;
  assign cfg_ready = 1'b1;

  assign out_valid  = out_valid_r;
  assign out_drive  = out_drive_r;
  assign out_moving = out_moving_r;
  assign out_finish = out_finish_r;

  ppms_close u_tgt_near (
    .a_i       (tgt_r),
    .b_i       (pos_r),
    .abs_tol_i (abs_tol_r),
    .close_o   (tgt_near)
  );

  ppms_close u_settle_close (
    .a_i       (pos_r),
    .b_i       (ref_pos_r),
    .abs_tol_i (abs_tol_r),
    .close_o   (settle_close)
  );

  ppms_pid u_pid (
    .gains_i    (gains_r),
    .setpoint_i (setpoint_r),
    .pos_i      (pos_r),
    .prev_pos_i (prev_pos_r),
    .integ_i    (integ_r),
    .integ_o    (pid_integ),
    .drive_o    (pid_drive)
  );

  // Next move state for the request in the input register
  always_comb begin
    setpoint_nxt     = setpoint_r;
    integ_nxt        = integ_r;
    prev_pos_nxt     = prev_pos_r;
    loop_active_nxt  = loop_active_r;
    move_active_nxt  = move_active_r;
    since_sample_nxt = since_sample_r;
    since_check_nxt  = since_check_r;
    since_start_nxt  = since_start_r;
    still_nxt        = still_r;
    ref_pos_nxt      = ref_pos_r;
    drive_nxt        = drive_r;
    fin_nxt          = FIN_NONE;

    unique case (func_r)
      FN_TICK: begin
        if (move_active_r && since_start_r != '1) since_start_nxt = since_start_r + 1'b1;
        // controller update when the sample period is due
        if (loop_active_r) begin
          if (since_sample_r != '1) since_sample_nxt = since_sample_r + 1'b1;
          if (since_sample_nxt >= sample_period_r) begin
            since_sample_nxt = '0;
            integ_nxt        = pid_integ;
            prev_pos_nxt     = pos_r;
            drive_nxt        = pid_drive;
          end
        end
        // stillness check
        if (move_active_r) begin
          if (since_check_r != '1) since_check_nxt = since_check_r + 1'b1;
          if (since_check_nxt >= settle_window_r) begin
            since_check_nxt = '0;
            if (settle_close) begin
              if (still_r != '1) still_nxt = still_r + 1'b1;
            end else begin
              ref_pos_nxt = pos_r;
              still_nxt   = '0;
            end
            if (still_nxt > settle_count_r) begin
              loop_active_nxt = 1'b0;
              move_active_nxt = 1'b0;
              drive_nxt       = '0;
              fin_nxt         = FIN_SETTLED;
            end
          end
        end
        // run time limit
        if (move_active_nxt && since_start_nxt > max_run_r) begin
          loop_active_nxt = 1'b0;
          move_active_nxt = 1'b0;
          drive_nxt       = '0;
          fin_nxt         = FIN_TIMEOUT;
        end
      end
      FN_GOTO: begin
        if (!tgt_near) begin
          move_active_nxt  = 1'b1;
          integ_nxt        = '0;
          since_start_nxt  = '0;
          since_check_nxt  = '0;
          still_nxt        = '0;
          ref_pos_nxt      = pos_r;
          setpoint_nxt     = tgt_r;
          prev_pos_nxt     = pos_r;
          loop_active_nxt  = 1'b1;
          since_sample_nxt = '0;
        end
      end
      FN_OPEN, FN_CLOSE: begin
        move_active_nxt = 1'b1;
        integ_nxt       = '0;
        since_start_nxt = '0;
        since_check_nxt = '0;
        still_nxt       = '0;
        ref_pos_nxt     = pos_r;
        loop_active_nxt = 1'b0;
        drive_nxt       = (func_r == FN_OPEN) ? DRIVE_NEG : DRIVE_POS;
      end
      FN_STOP: begin
        loop_active_nxt = 1'b0;
        move_active_nxt = 1'b0;
        drive_nxt       = '0;
        fin_nxt         = FIN_STOPPED;
      end
      default: begin
        // unused codes leave the state alone
      end
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gains_r.gain_p  <= GAIN_W'(65536);
      gains_r.gain_i  <= '0;
      gains_r.gain_d  <= '0;
      sample_period_r <= PER_W'(10);
      settle_window_r <= PER_W'(100);
      settle_count_r  <= STILL_W'(5);
      max_run_r       <= RUN_W'(60000);
      abs_tol_r       <= TOL_W'(2);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_GAIN_P:        gains_r.gain_p  <= cfg_data[GAIN_W-1:0];
        REG_GAIN_I:        gains_r.gain_i  <= cfg_data[GAIN_W-1:0];
        REG_GAIN_D:        gains_r.gain_d  <= cfg_data[GAIN_W-1:0];
        REG_SAMPLE_PERIOD: sample_period_r <= cfg_data[PER_W-1:0];
        REG_SETTLE_WINDOW: settle_window_r <= cfg_data[PER_W-1:0];
        REG_SETTLE_COUNT:  settle_count_r  <= cfg_data[STILL_W-1:0];
        REG_MAX_RUN:       max_run_r       <= cfg_data[RUN_W-1:0];
        REG_ABS_TOL:       abs_tol_r       <= cfg_data[TOL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      func_r <= in_func;
      pos_r  <= in_position;
      tgt_r  <= in_target;
    end
  end

  // Move state commits as the request moves into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setpoint_r     <= '0;
      integ_r        <= '0;
      prev_pos_r     <= '0;
      loop_active_r  <= 1'b0;
      move_active_r  <= 1'b0;
      since_sample_r <= '0;
      since_check_r  <= '0;
      since_start_r  <= '0;
      still_r        <= '0;
      ref_pos_r      <= '0;
      drive_r        <= '0;
    end else if (advance) begin
      setpoint_r     <= setpoint_nxt;
      integ_r        <= integ_nxt;
      prev_pos_r     <= prev_pos_nxt;
      loop_active_r  <= loop_active_nxt;
      move_active_r  <= move_active_nxt;
      since_sample_r <= since_sample_nxt;
      since_check_r  <= since_check_nxt;
      since_start_r  <= since_start_nxt;
      still_r        <= still_nxt;
      ref_pos_r      <= ref_pos_nxt;
      drive_r        <= drive_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_drive_r  <= drive_nxt;
      out_moving_r <= move_active_nxt;
      out_finish_r <= fin_nxt;
    end
  end

endmodule

@@ sv/ppms_checker.sv @@
module ppms_checker import ppms_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [DRV_W-1:0] out_drive,
  input logic                    out_moving,
  input logic [1:0]              out_finish
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_drive) &&
      $stable(out_moving) && $stable(out_finish))
    else $error("result changed while stalled");

  // With no move in progress the motor is braked
  a_idle_brake: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_moving |-> out_drive == '0)
    else $error("drive nonzero while idle");

  // Any finish code ends the move
  a_finish_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_finish != FIN_NONE |-> !out_moving)
    else $error("move still active after finish");

  // Drive stays within the symmetric limit
  a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_drive >= -$signed(DRV_W'(DRIVE_MAX)) &&
      out_drive <= $signed(DRV_W'(DRIVE_MAX)))
    else $error("drive out of range");

endmodule

bind position_pid_move_supervisor ppms_checker u_ppms_checker (.*);
